// File: design/bpyb_pkg.sv
// ----------------------------------------------------------------------------
// bpyb_pkg
// Shared widths, constants and register map of the bond price core.
// ----------------------------------------------------------------------------
package bpyb_pkg;

   // field widths
   localparam int YIELD_W = 25;
   localparam int FACE_W  = 32;
   localparam int YEARS_W = 6;
   localparam int RATE_W  = 25;
   localparam int FREQ_W  = 4;
   localparam int PRICE_W = 48;
   localparam int BUMP_W  = 21;

   // parameter defaults
   localparam int MAX_YEARS_DEF     = 63;
   localparam int MAX_FREQUENCY_DEF = 12;

   // Q1.30 discount factor format
   localparam int Q_FRAC = 30;
   localparam int DF_W   = Q_FRAC + 1;

   // configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_YIELD_BUMP = '0;
   localparam logic [BUMP_W-1:0]    YIELD_BUMP_RESET = 21'd16777;

endpackage

// File: design/bpyb_if.sv
// ----------------------------------------------------------------------------
// bpyb_req_if / bpyb_rsp_if
// Valid/ready channels carrying bond requests and price responses.
// ----------------------------------------------------------------------------
interface bpyb_req_if;
   logic                           valid;
   logic                           ready;
   logic [bpyb_pkg::YIELD_W-1:0]   yield_rate;
   logic [bpyb_pkg::FACE_W-1:0]    face_value;
   logic [bpyb_pkg::YEARS_W-1:0]   years_to_maturity;
   logic [bpyb_pkg::RATE_W-1:0]    coupon_rate;
   logic [bpyb_pkg::FREQ_W-1:0]    payments_per_year;

   modport source (output valid, yield_rate, face_value, years_to_maturity,
                   coupon_rate, payments_per_year, input ready);
   modport sink   (input valid, yield_rate, face_value, years_to_maturity,
                   coupon_rate, payments_per_year, output ready);
endinterface

interface bpyb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bpyb_pkg::YIELD_W-1:0]   yield_echo;
   logic [bpyb_pkg::FACE_W-1:0]    face_echo;
   logic [bpyb_pkg::YEARS_W-1:0]   years_echo;
   logic [bpyb_pkg::PRICE_W-1:0]   price;
   logic [bpyb_pkg::PRICE_W-1:0]   price_up;
   logic [bpyb_pkg::PRICE_W-1:0]   price_down;

   modport source (output valid, yield_echo, face_echo, years_echo, price,
                   price_up, price_down, input ready);
   modport sink   (input valid, yield_echo, face_echo, years_echo, price,
                   price_up, price_down, output ready);
endinterface

// File: design/bond_price_with_yield_bump_core.sv
// ----------------------------------------------------------------------------
// bond_price_with_yield_bump_core
// Coupon bond present value at the yield and at the yield +/- a bump.
// ----------------------------------------------------------------------------
// Each transaction runs the coupon division, three discount factor divisions
//   (NUM_W = 59 by default) and, unless years is zero, the period loop; a new request
//   is taken only once the previous response is loaded. The restoring divider (one
//   bit per cycle) and one shared 32x31 multiplier (nine products per period) do the work.
// A finished response waits in the output register while the next request
//   is taken. Synchronous active-high reset clears control and sets
//   yield_bump to its reset value.
// ----------------------------------------------------------------------------
module bond_price_with_yield_bump_core #(
   parameter int MAX_YEARS     = bpyb_pkg::MAX_YEARS_DEF,
   parameter int MAX_FREQUENCY = bpyb_pkg::MAX_FREQUENCY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bpyb_req_if.sink                          req_chan,
   bpyb_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpyb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpyb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpyb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int YW     = $clog2(MAX_YEARS + 1);
   localparam int FW     = $clog2(MAX_FREQUENCY + 1);
   localparam int Y2_W   = bpyb_pkg::YIELD_W + 1;
   localparam int DEN_W  = FW + 26;
   localparam int NUM_W  = (FW + 55 > 58) ? FW + 55 : 58;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int COUP_W = 42;
   localparam int CF_W   = COUP_W + 1;
   localparam int ACC_RAW = CF_W + $clog2(MAX_YEARS * MAX_FREQUENCY + 1);
   localparam int ACC_W  = (ACC_RAW > bpyb_pkg::PRICE_W) ? ACC_RAW : bpyb_pkg::PRICE_W + 1;
   localparam int DF_W   = bpyb_pkg::DF_W;
   localparam int PROD_W = 63;

   localparam logic [DF_W-1:0]   DF_ONE   = DF_W'(1) << bpyb_pkg::Q_FRAC;
   localparam logic [PROD_W-1:0] HALF_Q30 = PROD_W'(1) << (bpyb_pkg::Q_FRAC - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CMUL      = 3'd1;
   localparam logic [2:0] ST_DIV_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV_RUN   = 3'd3;
   localparam logic [2:0] ST_DIV_STORE = 3'd4;
   localparam logic [2:0] ST_MAC       = 3'd5;
   localparam logic [2:0] ST_FINISH    = 3'd6;
   localparam logic [2:0] ST_OUT       = 3'd7;

   // divisions, in order
   localparam logic [1:0] DIV_COUPON = 2'd0;
   localparam logic [1:0] DIV_D0     = 2'd1;
   localparam logic [1:0] DIV_D1     = 2'd2;
   localparam logic [1:0] DIV_D2     = 2'd3;

   // multiplier steps within one period
   localparam logic [3:0] STEP_F0  = 4'd0;
   localparam logic [3:0] STEP_F1  = 4'd1;
   localparam logic [3:0] STEP_F2  = 4'd2;
   localparam logic [3:0] STEP_LO0 = 4'd3;
   localparam logic [3:0] STEP_HI0 = 4'd4;
   localparam logic [3:0] STEP_LO1 = 4'd5;
   localparam logic [3:0] STEP_HI1 = 4'd6;
   localparam logic [3:0] STEP_LO2 = 4'd7;
   localparam logic [3:0] STEP_HI2 = 4'd8;

   // configuration
   logic [bpyb_pkg::BUMP_W-1:0] bump_ff;
   logic                        csr_sel;

   // control
   logic [2:0]        state_ff;
   logic [1:0]        div_sel_ff;
   logic [CNT_W-1:0]  div_cnt_ff;
   logic [3:0]        step_ff;
   logic [3:0]        wb_step_ff;
   logic              wb_valid_ff;
   logic [YW-1:0]     yr_cnt_ff;
   logic [FW-1:0]     sub_cnt_ff;
   logic              rsp_valid_ff;

   // item payload
   logic [bpyb_pkg::YIELD_W-1:0] y_ff;
   logic [bpyb_pkg::FACE_W-1:0]  face_ff;
   logic [bpyb_pkg::YEARS_W-1:0] years_in_ff;
   logic [bpyb_pkg::RATE_W-1:0]  rate_ff;
   logic [YW-1:0]                years_ff;
   logic [FW-1:0]                m_ff;
   logic [Y2_W-1:0]              y_up_ff;
   logic [bpyb_pkg::YIELD_W-1:0] y_dn_ff;
   logic [COUP_W-1:0]            coupon_ff;
   logic [DF_W-1:0]              d0_ff, d1_ff, d2_ff;
   logic [DF_W-1:0]              f0_ff, f1_ff, f2_ff;
   logic [ACC_W-1:0]             s0_ff, s1_ff, s2_ff;
   logic [PROD_W-1:0]            p_ff;

   // divider
   logic [NUM_W-1:0]  q_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;

   // response register
   logic [bpyb_pkg::YIELD_W-1:0] o_yield_ff;
   logic [bpyb_pkg::FACE_W-1:0]  o_face_ff;
   logic [bpyb_pkg::YEARS_W-1:0] o_years_ff;
   logic [bpyb_pkg::PRICE_W-1:0] o_p0_ff, o_p1_ff, o_p2_ff;

   // combinational
   logic [YW-1:0]     years_sel;
   logic [FW-1:0]     m_sel;
   logic [Y2_W-1:0]   y_div;
   logic [DEN_W-1:0]  den_div;
   logic [NUM_W-1:0]  num_div;
   logic [DEN_W:0]    rem_shift;
   logic              q_bit;
   logic [YW-1:0]     yr_next;
   logic [FW-1:0]     sub_next;
   logic              last_period;
   logic [CF_W-1:0]   cf;
   logic [31:0]       mul_a;
   logic [DF_W-1:0]   mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [PROD_W-1:0] p_round;
   logic              req_fire;
   logic              out_load;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[bpyb_pkg::CSR_ADDR_W-1:2] == bpyb_pkg::REG_YIELD_BUMP;
   assign csr_prdata = csr_sel ? bpyb_pkg::CSR_DATA_W'(bump_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff <= bpyb_pkg::YIELD_BUMP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel) begin
         bump_ff <= csr_pwdata[bpyb_pkg::BUMP_W-1:0];
      end
   end

   // ---------------------------------------------------------------- input
   assign req_chan.ready = state_ff == ST_IDLE;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      if ({1'b0, req_chan.years_to_maturity} > MAX_YEARS) begin
         years_sel = YW'(MAX_YEARS);
      end else begin
         years_sel = YW'(req_chan.years_to_maturity);
      end
      if (req_chan.payments_per_year == '0) begin
         m_sel = FW'(1);
      end else if ({1'b0, req_chan.payments_per_year} > MAX_FREQUENCY) begin
         m_sel = FW'(MAX_FREQUENCY);
      end else begin
         m_sel = FW'(req_chan.payments_per_year);
      end
   end

   // ---------------------------------------------------------------- divider
   always_comb begin
      case (div_sel_ff)
         DIV_D0:  y_div = Y2_W'(y_ff);
         DIV_D1:  y_div = y_up_ff;
         default: y_div = Y2_W'(y_dn_ff);
      endcase
      den_div = (DEN_W'(m_ff) << 24) + DEN_W'(y_div);
      if (div_sel_ff == DIV_COUPON) begin
         // (face*rate + m*2^15) / (m*2^16)
         num_div = NUM_W'(p_ff) + (NUM_W'(m_ff) << 15);
      end else begin
         // round(m*2^54 / (m*2^24 + y))
         num_div = (NUM_W'(m_ff) << 54) + NUM_W'(den_div >> 1);
      end
      rem_shift = {rem_ff, q_ff[NUM_W-1]};
      q_bit     = rem_shift >= {1'b0, den_ff};
   end

   // ---------------------------------------------------------------- period loop
   assign yr_next     = yr_cnt_ff + YW'(1);
   assign sub_next    = sub_cnt_ff + FW'(1);
   assign last_period = (yr_next == years_ff) && (sub_next == m_ff);
   assign cf          = CF_W'(coupon_ff) +
                        (last_period ? (CF_W'(face_ff) << 8) : CF_W'(0));

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CMUL) begin
         mul_a = face_ff;
         mul_b = DF_W'(rate_ff);
      end else begin
         unique case (step_ff)
            STEP_F0:  begin mul_a = 32'(f0_ff); mul_b = d0_ff; end
            STEP_F1:  begin mul_a = 32'(f1_ff); mul_b = d1_ff; end
            STEP_F2:  begin mul_a = 32'(f2_ff); mul_b = d2_ff; end
            STEP_LO0: begin mul_a = 32'(cf[bpyb_pkg::Q_FRAC-1:0]); mul_b = f0_ff; end
            STEP_HI0: begin mul_a = 32'(cf[CF_W-1:bpyb_pkg::Q_FRAC]); mul_b = f0_ff; end
            STEP_LO1: begin mul_a = 32'(cf[bpyb_pkg::Q_FRAC-1:0]); mul_b = f1_ff; end
            STEP_HI1: begin mul_a = 32'(cf[CF_W-1:bpyb_pkg::Q_FRAC]); mul_b = f1_ff; end
            STEP_LO2: begin mul_a = 32'(cf[bpyb_pkg::Q_FRAC-1:0]); mul_b = f2_ff; end
            STEP_HI2: begin mul_a = 32'(cf[CF_W-1:bpyb_pkg::Q_FRAC]); mul_b = f2_ff; end
            default:  begin mul_a = '0; mul_b = '0; end
         endcase
      end
      mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
      p_round = (p_ff + HALF_Q30) >> bpyb_pkg::Q_FRAC;
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_sel_ff   <= DIV_COUPON;
         div_cnt_ff   <= '0;
         step_ff      <= STEP_F0;
         wb_step_ff   <= STEP_F0;
         wb_valid_ff  <= 1'b0;
         yr_cnt_ff    <= '0;
         sub_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= state_ff == ST_MAC;
         wb_step_ff  <= step_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_CMUL;
               end
            end
            ST_CMUL: begin
               div_sel_ff <= DIV_COUPON;
               state_ff   <= ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               div_cnt_ff <= div_cnt_ff + CNT_W'(1);
               if (div_cnt_ff == CNT_W'(NUM_W - 1)) begin
                  state_ff <= ST_DIV_STORE;
               end
            end
            ST_DIV_STORE: begin
               step_ff    <= STEP_F0;
               yr_cnt_ff  <= '0;
               sub_cnt_ff <= '0;
               if (div_sel_ff != DIV_D2) begin
                  div_sel_ff <= div_sel_ff + 2'd1;
                  state_ff   <= ST_DIV_LOAD;
               end else if (years_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (step_ff == STEP_HI2) begin
                  step_ff <= STEP_F0;
                  if (sub_next == m_ff) begin
                     sub_cnt_ff <= '0;
                     yr_cnt_ff  <= yr_next;
                  end else begin
                     sub_cnt_ff <= sub_next;
                  end
                  if (last_period) begin
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         y_ff        <= req_chan.yield_rate;
         face_ff     <= req_chan.face_value;
         years_in_ff <= req_chan.years_to_maturity;
         rate_ff     <= req_chan.coupon_rate;
         years_ff    <= years_sel;
         m_ff        <= m_sel;
         y_up_ff     <= Y2_W'(req_chan.yield_rate) + Y2_W'(bump_ff);
         y_dn_ff     <= (req_chan.yield_rate > bpyb_pkg::YIELD_W'(bump_ff)) ?
                        req_chan.yield_rate - bpyb_pkg::YIELD_W'(bump_ff) : '0;
      end

      if (state_ff == ST_CMUL || state_ff == ST_MAC) begin
         p_ff <= mul_p;
      end

      if (state_ff == ST_DIV_LOAD) begin
         q_ff   <= num_div;
         rem_ff <= '0;
         den_ff <= (div_sel_ff == DIV_COUPON) ? (DEN_W'(m_ff) << 16) : den_div;
      end else if (state_ff == ST_DIV_RUN) begin
         q_ff   <= {q_ff[NUM_W-2:0], q_bit};
         rem_ff <= q_bit ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
      end

      if (state_ff == ST_DIV_STORE) begin
         case (div_sel_ff)
            DIV_COUPON: coupon_ff <= q_ff[COUP_W-1:0];
            DIV_D0:     d0_ff     <= q_ff[DF_W-1:0];
            DIV_D1:     d1_ff     <= q_ff[DF_W-1:0];
            default:    d2_ff     <= q_ff[DF_W-1:0];
         endcase
         f0_ff <= DF_ONE;
         f1_ff <= DF_ONE;
         f2_ff <= DF_ONE;
         s0_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (wb_valid_ff) begin
         // hi parts carry weight 2^30, so they add unrounded
         case (wb_step_ff)
            STEP_F0:  f0_ff <= p_round[DF_W-1:0];
            STEP_F1:  f1_ff <= p_round[DF_W-1:0];
            STEP_F2:  f2_ff <= p_round[DF_W-1:0];
            STEP_LO0: s0_ff <= s0_ff + ACC_W'(p_round);
            STEP_HI0: s0_ff <= s0_ff + ACC_W'(p_ff);
            STEP_LO1: s1_ff <= s1_ff + ACC_W'(p_round);
            STEP_HI1: s1_ff <= s1_ff + ACC_W'(p_ff);
            STEP_LO2: s2_ff <= s2_ff + ACC_W'(p_round);
            STEP_HI2: s2_ff <= s2_ff + ACC_W'(p_ff);
            default:  ;
         endcase
      end

      if (out_load) begin
         o_yield_ff <= y_ff;
         o_face_ff  <= face_ff;
         o_years_ff <= years_in_ff;
         o_p0_ff    <= (|s0_ff[ACC_W-1:bpyb_pkg::PRICE_W]) ? '1 : s0_ff[bpyb_pkg::PRICE_W-1:0];
         o_p1_ff    <= (|s1_ff[ACC_W-1:bpyb_pkg::PRICE_W]) ? '1 : s1_ff[bpyb_pkg::PRICE_W-1:0];
         o_p2_ff    <= (|s2_ff[ACC_W-1:bpyb_pkg::PRICE_W]) ? '1 : s2_ff[bpyb_pkg::PRICE_W-1:0];
      end
   end

   // ---------------------------------------------------------------- output
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.yield_echo = o_yield_ff;
   assign rsp_chan.face_echo  = o_face_ff;
   assign rsp_chan.years_echo = o_years_ff;
   assign rsp_chan.price      = o_p0_ff;
   assign rsp_chan.price_up   = o_p1_ff;
   assign rsp_chan.price_down = o_p2_ff;

endmodule
